### hdl/lpme_pkg.sv
package lpme_pkg;

  localparam int unsigned PIXELS_W     = 32;
  localparam int unsigned RESET_PIXELS = 14;
  localparam int unsigned CH_PER_PIXEL = 3;
  localparam int unsigned BYTE_W       = 8;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_MESSAGE,
    PH_DONE
  } phase_t;

  // The only part of a pixel the extractor needs: the restart flag and the
  // three channel LSBs, blue in bit 0, green in bit 1, red in bit 2.
  typedef struct packed {
    logic                    first_pixel;
    logic [CH_PER_PIXEL-1:0] lsbs;
  } pix_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;
    logic              is_error;
  } result_t;

endpackage

### hdl/lpme_if.sv
interface lpme_pix_if;
  logic       valid;
  logic       ready;
  logic       first_pixel;
  logic [7:0] blue_value;
  logic [7:0] green_value;
  logic [7:0] red_value;

  modport source (output valid, first_pixel, blue_value, green_value, red_value,
                  input ready);
  modport sink (input valid, first_pixel, blue_value, green_value, red_value,
                output ready);
endinterface

interface lpme_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       is_error;

  modport source (output valid, data_byte, is_last, is_error, input ready);
  modport sink (input valid, data_byte, is_last, is_error, output ready);
endinterface

### hdl/lsb_pixel_message_extractor.sv
// Recovers a message hidden in the pixel LSBs of an image streamed one pixel per
// word. Each pixel gives three stream bits (blue, green, red LSB); the first
// HEADER_BITS bits give the message length in bits, most significant first. A
// zero length, or one above 3 * image_pixels - HEADER_BITS, yields one error
// word; otherwise each complete message byte is returned, first bit in bit 7,
// with is_last on the final one, and a trailing partial byte is dropped. Set
// first_pixel on the first pixel of each image. One pixel is accepted every
// cycle unless the result output is stalled; each pixel passes through the input
// register, the single decode stage and the result register.
// Write image_pixels only while no pixel is in flight.
module lsb_pixel_message_extractor #(
  parameter int unsigned HEADER_BITS = 42
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lpme_pkg::PIXELS_W-1:0] cfg_wr_data,
  lpme_pix_if.sink                      in_pix,
  lpme_res_if.source                    out_res
);

  logic           s1_valid;
  logic           s1_take;
  lpme_pkg::pix_t s1_pix;

  lpme_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_pix   (s1_pix)
  );

  lpme_decode #(
    .HEADER_BITS (HEADER_BITS)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_valid    (s1_valid),
    .s1_pix      (s1_pix),
    .s1_take     (s1_take),
    .out_res     (out_res)
  );

endmodule

### hdl/lpme_in_stage.sv
module lpme_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  lpme_pix_if.sink        in_pix,
  input  logic            s1_take,
  output logic            s1_valid,
  output lpme_pkg::pix_t  s1_pix
);

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  lpme_pkg::pix_t s1_pix_r;
  logic           in_take;

  assign in_pix.ready = !s1_valid_r || s1_take;
  assign in_take      = in_pix.valid && in_pix.ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r.first_pixel <= in_pix.first_pixel;
      s1_pix_r.lsbs        <= {in_pix.red_value[0], in_pix.green_value[0],
                               in_pix.blue_value[0]};
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_pix   = s1_pix_r;

endmodule

### hdl/lpme_decode.sv
module lpme_decode #(
  parameter int unsigned HEADER_BITS = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lpme_pkg::PIXELS_W-1:0]     cfg_wr_data,
  input  logic                              s1_valid,
  input  lpme_pkg::pix_t                    s1_pix,
  output logic                              s1_take,
  lpme_res_if.source                        out_res
);

  localparam int unsigned HC_W  = $clog2(HEADER_BITS + 1);
  localparam int unsigned CAP_W = lpme_pkg::PIXELS_W + 2;
  localparam int unsigned CMP_W = (HEADER_BITS + 1 > CAP_W) ? HEADER_BITS + 1 : CAP_W;
  localparam int unsigned BB_W  = $clog2(lpme_pkg::BYTE_W);

  logic [CMP_W-1:0]                cap3_r;
  logic [CMP_W-1:0]                cap3_nxt;
  lpme_pkg::phase_t                phase_r, phase_nxt;
  logic [HEADER_BITS-1:0]          hdr_shift_r, hdr_shift_nxt;
  logic [HC_W-1:0]                 hdr_cnt_r, hdr_cnt_nxt;
  logic [HEADER_BITS-1:0]          bits_rem_r, bits_rem_nxt;
  logic [lpme_pkg::BYTE_W-1:0]     byte_shift_r, byte_shift_nxt;
  logic [BB_W-1:0]                 byte_cnt_r, byte_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  lpme_pkg::result_t               res_r, res_nxt;
  logic                            emit;

  assign s1_take  = s1_valid && (!out_valid_r || out_res.ready);
  assign cap3_nxt = CMP_W'({cfg_wr_data, 1'b0}) + CMP_W'(cfg_wr_data);

  // Walk the three bits of the pixel in stream order: blue, green, red.
  always_comb begin
    lpme_pkg::phase_t            ph;
    logic [HEADER_BITS-1:0]      hs;
    logic [HC_W-1:0]             hc;
    logic [HEADER_BITS-1:0]      br;
    logic [lpme_pkg::BYTE_W-1:0] bs;
    logic [BB_W-1:0]             bc;
    logic                        b;
    if (s1_pix.first_pixel) begin
      ph = lpme_pkg::PH_HEADER;
      hs = '0;
      hc = '0;
      br = '0;
      bs = '0;
      bc = '0;
    end else begin
      ph = phase_r;
      hs = hdr_shift_r;
      hc = hdr_cnt_r;
      br = bits_rem_r;
      bs = byte_shift_r;
      bc = byte_cnt_r;
    end
    emit    = 1'b0;
    res_nxt = '0;
    for (int i = 0; i < lpme_pkg::CH_PER_PIXEL; i++) begin
      b = s1_pix.lsbs[i];
      case (ph)
        lpme_pkg::PH_HEADER: begin
          hs = {hs[HEADER_BITS-2:0], b};
          hc = hc + HC_W'(1);
          if (hc == HC_W'(HEADER_BITS)) begin
            if ((hs == '0) || (CMP_W'(hs) + CMP_W'(HEADER_BITS) > cap3_r)) begin
              emit             = 1'b1;
              res_nxt.is_error = 1'b1;
              ph               = lpme_pkg::PH_DONE;
            end else begin
              br = hs;
              bs = '0;
              bc = '0;
              ph = lpme_pkg::PH_MESSAGE;
            end
          end
        end
        lpme_pkg::PH_MESSAGE: begin
          bs = {bs[lpme_pkg::BYTE_W-2:0], b};
          br = br - HEADER_BITS'(1);
          if (bc == BB_W'(lpme_pkg::BYTE_W - 1)) begin
            emit              = 1'b1;
            res_nxt.data_byte = bs;
            res_nxt.is_last   = (br < HEADER_BITS'(lpme_pkg::BYTE_W));
            bs                = '0;
            bc                = '0;
            if (res_nxt.is_last) begin
              ph = lpme_pkg::PH_DONE;
            end
          end else begin
            bc = bc + BB_W'(1);
            if (br == '0) begin
              ph = lpme_pkg::PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
    phase_nxt      = ph;
    hdr_shift_nxt  = hs;
    hdr_cnt_nxt    = hc;
    bits_rem_nxt   = br;
    byte_shift_nxt = bs;
    byte_cnt_nxt   = bc;
  end

  assign out_valid_nxt = s1_take ? emit : (out_valid_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap3_r       <= CMP_W'(lpme_pkg::RESET_PIXELS * lpme_pkg::CH_PER_PIXEL);
      phase_r      <= lpme_pkg::PH_HEADER;
      hdr_shift_r  <= '0;
      hdr_cnt_r    <= '0;
      bits_rem_r   <= '0;
      byte_shift_r <= '0;
      byte_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap3_r <= cap3_nxt;
      end
      if (s1_take) begin
        phase_r      <= phase_nxt;
        hdr_shift_r  <= hdr_shift_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        bits_rem_r   <= bits_rem_nxt;
        byte_shift_r <= byte_shift_nxt;
        byte_cnt_r   <= byte_cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    out_res.valid     = out_valid_r;
    out_res.data_byte = res_r.data_byte;
    out_res.is_last   = res_r.is_last;
    out_res.is_error  = res_r.is_error;
  end

  a_err_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.is_error && res_r.is_last))
    else $error("error word also marked as last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.is_error) |-> (res_r.data_byte == '0))
    else $error("error word carries data");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && emit && res_nxt.is_error) |=> (phase_r == lpme_pkg::PH_DONE))
    else $error("extraction continues after an error word");

  a_msg_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpme_pkg::PH_MESSAGE) |-> (bits_rem_r != '0))
    else $error("message phase with no bits remaining");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && emit && res_nxt.is_last) |=> (phase_r == lpme_pkg::PH_DONE))
    else $error("extraction continues after the last word");

endmodule

### bench/lsb_pixel_message_extractor_tb.sv
`timescale 1ns / 1ps

module lsb_pixel_message_extractor_tb;

  localparam int unsigned HDR_BITS = 42;
  localparam int unsigned SEGMENTS = 6;
  localparam int unsigned SEGMENT_ITEMS = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SCRIPT_ROWS = 21;

  localparam lpme_pkg::result_t NO_WORD = '0;
  localparam lpme_pkg::result_t LENGTH_ERROR = '{data_byte: 8'h00, is_last: 1'b0,
                                                 is_error: 1'b1};

  typedef struct {
    logic       first_pixel;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_word_t;

  typedef struct {
    pixel_word_t       pix;
    bit                typed;
    bit                has_res;
    lpme_pkg::result_t res;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [lpme_pkg::PIXELS_W-1:0] cfg_wr_data;

  lpme_pix_if pix_if ();
  lpme_res_if res_if ();

  lsb_pixel_message_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_pix     (pix_if),
    .out_res    (res_if)
  );

  // Expected words, oldest first.
  lpme_pkg::result_t pending_bytes[$];
  pixel_word_t pixel_plan[$];

  // Shadow of the extractor state.
  logic [lpme_pkg::PIXELS_W-1:0] image_pixels_cfg;
  lpme_pkg::phase_t              ext_phase;
  logic [HDR_BITS-1:0]           hdr_sr;
  int unsigned                   hdr_bits;
  logic [HDR_BITS-1:0]           msg_bits_left;
  logic [7:0]                    byte_sr;
  int unsigned                   byte_bits;

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned live_items;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_off_req;

  // Full ones and then a trailing pixel under the reset pixel count, followed by restarts
  // part-way through a header.
  pixel_row_t pixel_script [SCRIPT_ROWS] = '{
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b1, LENGTH_ERROR},
    '{'{1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, NO_WORD},
    '{'{1'b1, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hFE, 8'h01, 8'hFE}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b1, 8'h01, 8'hFE, 8'h01}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'hAA, 8'h55, 8'hAA}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b0, 8'h55, 8'hAA, 8'h55}, 1'b0, 1'b0, NO_WORD},
    '{'{1'b1, 8'hFF, 8'h00, 8'hFF}, 1'b0, 1'b0, NO_WORD}
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void restart_extraction();
    ext_phase = lpme_pkg::PH_HEADER;
    hdr_sr = '0;
    hdr_bits = 0;
    msg_bits_left = '0;
    byte_sr = '0;
    byte_bits = 0;
  endfunction

  function automatic bit extract_pixel(input pixel_word_t p, output lpme_pkg::result_t res);
    logic [2:0]  lsbs;
    logic [63:0] capacity;
    bit          got;
    int          i;
    got = 1'b0;
    res = NO_WORD;
    if (p.first_pixel) begin
      restart_extraction();
    end
    lsbs = {p.red[0], p.green[0], p.blue[0]};
    for (i = 0; i < 3; i++) begin
      if (ext_phase == lpme_pkg::PH_HEADER) begin
        hdr_sr = {hdr_sr[HDR_BITS-2:0], lsbs[i]};
        hdr_bits++;
        if (hdr_bits >= HDR_BITS) begin
          capacity = 64'(image_pixels_cfg) * 64'd3;
          if (hdr_sr == '0 || 64'(hdr_sr) + 64'(HDR_BITS) > capacity) begin
            res = LENGTH_ERROR;
            ext_phase = lpme_pkg::PH_DONE;
            return 1'b1;
          end
          msg_bits_left = hdr_sr;
          byte_sr = '0;
          byte_bits = 0;
          ext_phase = lpme_pkg::PH_MESSAGE;
        end
      end else if (ext_phase == lpme_pkg::PH_MESSAGE) begin
        byte_sr = {byte_sr[6:0], lsbs[i]};
        byte_bits++;
        msg_bits_left--;
        if (byte_bits == 8) begin
          res.data_byte = byte_sr;
          res.is_last = (msg_bits_left < 8);
          got = 1'b1;
          byte_sr = '0;
          byte_bits = 0;
          if (res.is_last) begin
            ext_phase = lpme_pkg::PH_DONE;
          end
        end else if (msg_bits_left == '0) begin
          ext_phase = lpme_pkg::PH_DONE;
        end
      end
    end
    return got;
  endfunction

  // Queues the pixels of one image: a header carrying a chosen length, the message bits,
  // a few trailing bits, sometimes cut short. One image in ten is unstructured noise.
  function automatic void plan_image();
    longint          cap_len;
    longint          hi;
    logic [HDR_BITS-1:0] len;
    bit              stream[$];
    bit              is_err;
    int unsigned     roll;
    int unsigned     msg_bits;
    int unsigned     npix;
    int unsigned     k;
    pixel_word_t     p;
    cap_len = 3 * longint'(image_pixels_cfg) - longint'(HDR_BITS);
    if ($urandom_range(9) == 0) begin
      npix = $urandom_range(20, 1);
      for (k = 0; k < npix; k++) begin
        p.first_pixel = ($urandom_range(4) == 0);
        p.blue = 8'($urandom);
        p.green = 8'($urandom);
        p.red = 8'($urandom);
        pixel_plan.push_back(p);
      end
      return;
    end
    hi = (cap_len < 240) ? cap_len : 240;
    roll = $urandom_range(99);
    if (roll < 10) begin
      len = '0;
    end else if (roll < 22) begin
      len = $urandom_range(1) ? HDR_BITS'(cap_len + 1) : '1;
    end else if (roll < 37) begin
      len = HDR_BITS'($urandom_range(7, 1));
    end else if (roll < 42 && cap_len >= 1 && cap_len <= 240) begin
      len = HDR_BITS'(cap_len);
    end else if (hi < 1) begin
      len = HDR_BITS'($urandom_range(12, 1));
    end else if (hi < 8) begin
      len = HDR_BITS'($urandom_range(int'(hi), 1));
    end else begin
      len = HDR_BITS'($urandom_range(int'(hi), 8));
    end
    is_err = (len == '0) || (longint'(len) > cap_len);
    msg_bits = is_err ? 0 : int'(len);
    for (k = 0; k < HDR_BITS; k++) begin
      stream.push_back(len[HDR_BITS-1-k]);
    end
    for (k = 0; k < msg_bits + $urandom_range(8); k++) begin
      stream.push_back(bit'($urandom));
    end
    while (stream.size() % 3 != 0) begin
      stream.push_back(bit'($urandom));
    end
    npix = stream.size() / 3;
    if ($urandom_range(99) < 8) begin
      npix = $urandom_range(npix, 1);
    end
    for (k = 0; k < npix; k++) begin
      p.first_pixel = (k == 0) && ($urandom_range(19) != 0);
      p.blue = {7'($urandom), stream[3*k]};
      p.green = {7'($urandom), stream[3*k+1]};
      p.red = {7'($urandom), stream[3*k+2]};
      pixel_plan.push_back(p);
    end
  endfunction

  task automatic send_pixel(input pixel_word_t p, input bit typed, input bit has_res,
                            input lpme_pkg::result_t typed_res);
    lpme_pkg::result_t res;
    bit                got;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    pix_if.valid <= 1'b1;
    pix_if.first_pixel <= p.first_pixel;
    pix_if.blue_value <= p.blue;
    pix_if.green_value <= p.green;
    pix_if.red_value <= p.red;
    do @(posedge clk); while (!pix_if.ready);
    if (p.first_pixel || ext_phase != lpme_pkg::PH_DONE) begin
      live_items++;
    end
    got = extract_pixel(p, res);
    if (typed) begin
      if (has_res) begin
        pending_bytes.push_back(typed_res);
      end
    end else if (got) begin
      pending_bytes.push_back(res);
    end
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_image_pixels(input logic [lpme_pkg::PIXELS_W-1:0] value);
    wait_for_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    image_pixels_cfg = value;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        src_idle_pct = 12;
        sink_idle_pct = 88;
      end
      1: begin
        src_idle_pct = 88;
        sink_idle_pct = 12;
      end
      default: begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
    endcase
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : word_check
    lpme_pkg::result_t got;
    lpme_pkg::result_t want;
    if (res_if.valid && res_if.ready) begin
      got = '{data_byte: res_if.data_byte, is_last: res_if.is_last,
              is_error: res_if.is_error};
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected word: data_byte=%h is_last=%b is_error=%b",
                   got.data_byte, got.is_last, got.is_error);
        end
      end else begin
        want = pending_bytes.pop_front();
        if (got.data_byte !== want.data_byte || got.is_last !== want.is_last ||
            got.is_error !== want.is_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch: expected %h/%b/%b, got %h/%b/%b (data_byte/is_last/is_error)",
                     want.data_byte, want.is_last, want.is_error,
                     got.data_byte, got.is_last, got.is_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned seg;
    int unsigned row;
    logic [lpme_pkg::PIXELS_W-1:0] seg_pixels [SEGMENTS];
    mismatches = 0;
    cycle_count = 0;
    live_items = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    pix_if.valid = 1'b0;
    pix_if.first_pixel = 1'b0;
    pix_if.blue_value = '0;
    pix_if.green_value = '0;
    pix_if.red_value = '0;
    image_pixels_cfg = lpme_pkg::RESET_PIXELS;
    restart_extraction();
    set_idling(0);
    seg_pixels[0] = $urandom_range(60, 15);
    seg_pixels[1] = 32'hFFFF_FFFF;
    seg_pixels[2] = lpme_pkg::RESET_PIXELS;
    seg_pixels[3] = $urandom_range(100, 61);
    seg_pixels[4] = $urandom_range(30, 16);
    seg_pixels[5] = 32'hFFFF_FFFF;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < SCRIPT_ROWS; row++) begin
      send_pixel(pixel_script[row].pix, pixel_script[row].typed,
                 pixel_script[row].has_res, pixel_script[row].res);
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      set_idling(seg / 2);
      write_image_pixels(seg_pixels[seg]);
      if (seg == 4) begin
        hold_off_req = 1'b1;
      end
      live_items = 0;
      while (live_items < SEGMENT_ITEMS) begin
        plan_image();
        while (pixel_plan.size() != 0) begin
          send_pixel(pixel_plan.pop_front(), 1'b0, 1'b0, NO_WORD);
        end
      end
    end

    wait_for_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lpme_pkg.sv
hdl/lpme_if.sv
hdl/lpme_in_stage.sv
hdl/lpme_decode.sv
hdl/lsb_pixel_message_extractor.sv
bench/lsb_pixel_message_extractor_tb.sv
